FILE: rtl/apfp_pkg.sv
// Shared constants and helpers for the ASCII position frame parser.
package apfp_pkg;

  localparam int unsigned FRAME_LEN = 18;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned COORD_W   = 18;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_AXES  = 3;

  localparam logic [7:0] SIGN_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic signed [ACC_W-1:0] POS_LIMIT = ACC_W'(99999);

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK    = 2'd2;

  localparam logic [7:0]       HEADER_RST = 8'h54;
  localparam logic [7:0]       READY_RST  = 8'h52;
  localparam logic [CNT_W-1:0] ACK_RST    = 10'd100;

  localparam logic EV_FRAME = 1'b0;
  localparam logic EV_READY = 1'b1;

  // Role of one byte slot inside a frame.
  typedef struct packed {
    logic        is_sign;
    logic [1:0]  axis;
    logic [13:0] weight;
  } slot_t;

  // Result handed from the parse stage to the finishing stage.
  typedef struct packed {
    logic                               kind;
    logic [NUM_AXES-1:0][ACC_W-1:0]     mag;
    logic [NUM_AXES-1:0]                neg;
    logic                               ok;
    logic                               ack;
    logic                               ready;
  } evt_t;

  function automatic slot_t slot_info(input logic [POS_W-1:0] pos);
    slot_t      s;
    logic [2:0] k;
    if (pos < POS_W'(6)) begin
      s.axis = 2'd0;
      k      = pos[2:0];
    end else if (pos < POS_W'(12)) begin
      s.axis = 2'd1;
      k      = 3'(pos - POS_W'(6));
    end else begin
      s.axis = 2'd2;
      k      = 3'(pos - POS_W'(12));
    end
    s.is_sign = (k == 3'd0);
    case (k)
      3'd1:    s.weight = 14'd10000;
      3'd2:    s.weight = 14'd1000;
      3'd3:    s.weight = 14'd100;
      3'd4:    s.weight = 14'd10;
      3'd5:    s.weight = 14'd1;
      default: s.weight = 14'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/ascii_position_frame_parser.sv
// Top level of the ASCII position frame parser.
// The parser takes one received byte per cycle while in_stall_o is low and
// reports each result via the parse and output registers. While hunting, a
// header byte opens an 18-byte frame and a ready byte reports a ready event.
// Inside a frame every byte is folded into a running per-axis sum as it
// arrives (sign byte clears the sum, each digit adds its weighted value), so
// the last byte only has to add one digit; a second stage then applies the
// sign and clamps to plus or minus 99999 hundredths. The sustained rate of one
// byte per cycle is set by that accumulate step; the two pipeline registers
// let a new byte be taken while a finished result still waits on out_stall_i.
// Configuration writes take effect on the next clock edge.
module ascii_position_frame_parser
  import apfp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 event_kind_o,
  output logic [COORD_W-1:0]   pos_x_o,
  output logic [COORD_W-1:0]   pos_y_o,
  output logic [COORD_W-1:0]   pos_z_o,
  output logic                 digits_ok_o,
  output logic                 ack_request_o,
  output logic                 ready_res_o
);

  // Configuration registers.
  logic [7:0]       header_q;
  logic [7:0]       ready_byte_q;
  logic [CNT_W-1:0] ack_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= HEADER_RST;
      ready_byte_q <= READY_RST;
      ack_int_q    <= ACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER: header_q     <= cfg_data_i[7:0];
        CFG_READY:  ready_byte_q <= cfg_data_i[7:0];
        CFG_ACK:    ack_int_q    <= cfg_data_i[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Handshake between the parse stage, the finishing stage and the output.
  logic s1_valid_q;
  logic out_valid_q;
  logic s2_free;
  logic s2_load;
  logic in_xfer;

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s2_load    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Frame tracking state. The sticky ready flag needs no register of its
  // own: every event sets it, so each reported event carries it as one.
  logic                         hunting_q;
  logic [POS_W-1:0]             pos_q;
  logic [CNT_W-1:0]             frame_cnt_q;
  logic [NUM_AXES-1:0][ACC_W-1:0] acc_q;
  logic [NUM_AXES-1:0]          neg_q;
  logic                         ok_q;

  slot_t                   slot;
  logic signed [8:0]       digit;
  logic signed [ACC_W-1:0] digit_ext;
  logic signed [ACC_W-1:0] weight_ext;
  logic signed [ACC_W-1:0] prod;
  logic                    is_digit;
  logic                    last_byte;
  logic                    hdr_hit;
  logic                    rdy_hit;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    ack_hit;

  always_comb begin
    slot       = slot_info(pos_q);
    digit      = $signed({1'b0, rx_byte_i} - {1'b0, CHAR_ZERO});
    digit_ext  = ACC_W'(digit);
    weight_ext = $signed(ACC_W'({1'b0, slot.weight}));
    prod       = digit_ext * weight_ext;
    is_digit   = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
    last_byte  = (pos_q == POS_W'(FRAME_LEN - 1));
    hdr_hit    = hunting_q && (rx_byte_i == header_q);
    rdy_hit    = hunting_q && !hdr_hit && (rx_byte_i == ready_byte_q);
    cnt_inc    = frame_cnt_q + CNT_W'(1);
    ack_hit    = (cnt_inc == ack_int_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q    <= 1'b1;
      pos_q        <= '0;
      frame_cnt_q  <= '0;
    end else if (in_xfer) begin
      if (hunting_q) begin
        if (hdr_hit) begin
          hunting_q <= 1'b0;
          pos_q     <= '0;
        end
      end else if (last_byte) begin
        hunting_q    <= 1'b1;
        pos_q        <= '0;
        frame_cnt_q  <= ack_hit ? '0 : cnt_inc;
      end else begin
        pos_q <= pos_q + POS_W'(1);
      end
    end
  end

  // Running sums; a sign byte restarts its axis, the first one also the digit check.
  always_ff @(posedge clk_i) begin
    if (in_xfer && !hunting_q) begin
      if (slot.is_sign) begin
        acc_q[slot.axis] <= '0;
        neg_q[slot.axis] <= (rx_byte_i == SIGN_MINUS);
        if (pos_q == '0) begin
          ok_q <= 1'b1;
        end
      end else begin
        acc_q[slot.axis] <= acc_q[slot.axis] + prod;
        ok_q             <= ok_q && is_digit;
      end
    end
  end

  // Parse stage result register.
  evt_t s1_q;
  evt_t s1_d;
  logic s1_event;

  assign s1_event = in_xfer && (rdy_hit || (!hunting_q && last_byte));

  always_comb begin
    s1_d = '0;
    if (hunting_q) begin
      s1_d.kind  = EV_READY;
      s1_d.ready = 1'b1;
    end else begin
      s1_d.kind   = EV_FRAME;
      s1_d.mag[0] = acc_q[0];
      s1_d.mag[1] = acc_q[1];
      s1_d.mag[2] = acc_q[2] + prod;
      s1_d.neg    = neg_q;
      s1_d.ok     = ok_q && is_digit;
      s1_d.ack    = ack_hit;
      s1_d.ready  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_event) begin
      s1_valid_q <= 1'b1;
    end else if (s2_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_event) begin
      s1_q <= s1_d;
    end
  end

  // Finishing stage: sign and clamp each axis into the output register.
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;

  apfp_finish u_fin_x (.mag_i(s1_q.mag[0]), .neg_i(s1_q.neg[0]), .coord_o(coord_x));
  apfp_finish u_fin_y (.mag_i(s1_q.mag[1]), .neg_i(s1_q.neg[1]), .coord_o(coord_y));
  apfp_finish u_fin_z (.mag_i(s1_q.mag[2]), .neg_i(s1_q.neg[2]), .coord_o(coord_z));

  logic               kind_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [COORD_W-1:0] z_q;
  logic               ok_out_q;
  logic               ack_out_q;
  logic               ready_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (s2_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      kind_q      <= s1_q.kind;
      x_q         <= coord_x;
      y_q         <= coord_y;
      z_q         <= coord_z;
      ok_out_q    <= s1_q.ok;
      ack_out_q   <= s1_q.ack;
      ready_out_q <= s1_q.ready;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign pos_x_o       = x_q;
  assign pos_y_o       = y_q;
  assign pos_z_o       = z_q;
  assign digits_ok_o   = ok_out_q;
  assign ack_request_o = ack_out_q;
  assign ready_res_o   = ready_out_q;

  // While hunting the frame position always rests at the first slot.
  a_hunt_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hunting_q |-> (pos_q == '0))
    else $error("frame position not cleared while hunting");

  // The final frame byte always produces a pending frame result.
  a_last_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !hunting_q && last_byte) |=> (s1_valid_q && (s1_q.kind == EV_FRAME)))
    else $error("last frame byte did not produce a frame result");

  // A parse result that cannot move on is held, not dropped.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> s1_valid_q)
    else $error("parse result lost while output stalled");

  // Ready events carry zero coordinates and no frame flags.
  a_ready_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == EV_READY)) |->
      ((x_q == '0) && (y_q == '0) && (z_q == '0) && !ok_out_q && !ack_out_q && ready_out_q))
    else $error("ready event carries frame data");

endmodule

FILE: rtl/apfp_finish.sv
// Applies the sign to one coordinate magnitude and clamps it to the legal range.
module apfp_finish
  import apfp_pkg::*;
(
  input  logic [ACC_W-1:0]   mag_i,
  input  logic               neg_i,
  output logic [COORD_W-1:0] coord_o
);

  logic signed [ACC_W-1:0] val;
  logic signed [ACC_W-1:0] clamped;

  always_comb begin
    val = neg_i ? -$signed(mag_i) : $signed(mag_i);
    if (val > POS_LIMIT) begin
      clamped = POS_LIMIT;
    end else if (val < -POS_LIMIT) begin
      clamped = -POS_LIMIT;
    end else begin
      clamped = val;
    end
    coord_o = clamped[COORD_W-1:0];
  end

endmodule
